FILE: hdl/sm4_pkg.sv
// SM4 package: S-box, FK/CK constants, mode and register codes, round helpers.
// No dependencies.
package sm4_pkg;

  localparam int NumRounds = 32;
  localparam int RndW = 5;

  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW  = 3'd1;
  localparam logic [2:0] REG_IV_HIGH  = 3'd2;
  localparam logic [2:0] REG_IV_LOW   = 3'd3;
  localparam logic [2:0] REG_OP_MODE  = 3'd4;

  localparam logic [1:0] MODE_CTR = 2'd0;
  localparam logic [1:0] MODE_ENC = 2'd1;
  localparam logic [1:0] MODE_DEC = 2'd2;

  localparam logic [31:0] FK0 = 32'hA3B1BAC6;
  localparam logic [31:0] FK1 = 32'h56AA3350;
  localparam logic [31:0] FK2 = 32'h677D9197;
  localparam logic [31:0] FK3 = 32'hB27022DC;
  localparam logic [31:0] CK_STEP = 32'h00070E15;
  localparam logic [31:0] CK_LAST = 32'h646B7279;

  typedef struct packed {
    logic       load;   // start of a pass over the row
    logic       key_gen;
    logic [RndW-1:0] rnd;
  } rnd_ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau(input logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

FILE: hdl/sm4_if.sv
// Valid/ready word channels for the SM4 block: data in, result out, config.
// Depends on nothing.
interface sm4_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic        restart;
  modport source (output valid, data_high, data_low, restart, input ready);
  modport sink   (input valid, data_high, data_low, restart, output ready);
endinterface

interface sm4_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface sm4_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/sm4_cell.sv
// One 32-bit word cell of the SM4 shift row; the round itself is computed in sm4_rnd_func.
// Depends on sm4_pkg.
module sm4_cell import sm4_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  logic        shift,
  input  logic [31:0] load_word,
  input  logic [31:0] shift_in,
  output logic [31:0] word_out
);
  logic [31:0] word_r;
  logic [31:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (load) begin
      word_nxt = load_word;
    end else if (shift) begin
      word_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_out = word_r;
endmodule

FILE: hdl/sm4_round.sv
// SM4 round function (data or key schedule form) feeding the cell row.
// Depends on sm4_pkg.
module sm4_rnd_func import sm4_pkg::*; (
  input  logic        key_gen,
  input  logic [31:0] x0,
  input  logic [31:0] x1,
  input  logic [31:0] x2,
  input  logic [31:0] x3,
  input  logic [31:0] rk,
  output logic [31:0] nx
);
  logic [31:0] b;
  always_comb begin
    b = tau(x1 ^ x2 ^ x3 ^ rk);
    if (key_gen) begin
      nx = x0 ^ b ^ rol(b, 13) ^ rol(b, 23);
    end else begin
      nx = x0 ^ b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
    end
  end
endmodule

FILE: hdl/sm4_ctr_cipher.sv
// SM4 cipher with counter mode: top level with sequencer, key RAM and cell row.
// The result is registered on the last of the 32 rounds and held until taken;
// after a key change the 32-round key schedule runs first. A new word is
// accepted only once the result has been taken (accept, rounds, output);
// one round per cycle through the four-cell row.
// Reset (rst_n low, synchronous) clears config, counter, keys_valid and control.
module sm4_ctr_cipher import sm4_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  sm4_in_if.sink    in_ch,
  sm4_out_if.source out_ch,
  sm4_cfg_if.sink   cfg_ch
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEY  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]   st_r, st_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic [63:0]  key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic [1:0]   mode_r;
  logic         keys_valid_r;
  logic [127:0] ctr_r;
  logic [127:0] data_r;        // block to XOR in counter mode
  logic [127:0] pend_r;        // block held back while keys are derived
  logic [1:0]   run_mode_r;
  logic [31:0]  ck_r;
  logic [63:0]  res_hi_r, res_lo_r;
  logic [31:0]  rk_mem [NumRounds];
  logic [31:0]  rk_rd_r;
  logic [RndW-1:0] rd_addr;
  logic         rd_dec;
  logic [31:0]  w0, w1, w2, w3, nx;
  logic [127:0] load_blk, src_blk;
  rnd_ctl_t     ctl;
  logic         acc, cfg_acc, out_acc;

  assign acc     = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (st_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (st_r == ST_OUT);
  assign out_ch.result_high = res_hi_r;
  assign out_ch.result_low  = res_lo_r;

  // block source captured on accept; key load takes its own path
  assign src_blk = (mode_r == MODE_CTR)
                 ? (in_ch.restart ? {iv_hi_r, iv_lo_r} : ctr_r)
                 : {in_ch.data_high, in_ch.data_low};

  always_comb begin
    ctl.load    = 1'b0;
    ctl.key_gen = (st_r == ST_KEY);
    ctl.rnd     = rnd_r;
    load_blk    = src_blk;
    if (acc) begin
      ctl.load = 1'b1;
      if (!keys_valid_r) begin
        load_blk = {key_hi_r ^ {FK0, FK1}, key_lo_r ^ {FK2, FK3}};
      end
    end else if (st_r == ST_KEY && rnd_r == RndW'(NumRounds - 1)) begin
      ctl.load = 1'b1;
      load_blk = pend_r;
    end
  end

  // Cell row: cell 0 oldest word, new word enters cell 3.
  sm4_cell u_c0 (.clk, .load(ctl.load), .shift(st_r != ST_IDLE && st_r != ST_OUT),
                 .load_word(load_blk[127:96]), .shift_in(w1), .word_out(w0));
  sm4_cell u_c1 (.clk, .load(ctl.load), .shift(st_r != ST_IDLE && st_r != ST_OUT),
                 .load_word(load_blk[95:64]), .shift_in(w2), .word_out(w1));
  sm4_cell u_c2 (.clk, .load(ctl.load), .shift(st_r != ST_IDLE && st_r != ST_OUT),
                 .load_word(load_blk[63:32]), .shift_in(w3), .word_out(w2));
  sm4_cell u_c3 (.clk, .load(ctl.load), .shift(st_r != ST_IDLE && st_r != ST_OUT),
                 .load_word(load_blk[31:0]), .shift_in(nx), .word_out(w3));

  sm4_rnd_func u_rnd (.key_gen(ctl.key_gen), .x0(w0), .x1(w1), .x2(w2), .x3(w3),
                      .rk(ctl.key_gen ? ck_r : rk_rd_r), .nx(nx));

  // Round key read address runs one ahead of the round being worked.
  // While idle the run mode is not latched yet, so the live mode decides.
  always_comb begin
    rd_dec  = (st_r == ST_IDLE) ? (mode_r == MODE_DEC) : (run_mode_r == MODE_DEC);
    rd_addr = rnd_nxt;
    if (rd_dec) begin
      rd_addr = RndW'(NumRounds - 1) - rnd_nxt;
    end
  end

  // key written this edge is forwarded straight to the read register
  always_ff @(posedge clk) begin
    if (st_r == ST_KEY) begin
      rk_mem[ctl.rnd] <= nx;
    end
    if (st_r == ST_KEY && ctl.rnd == rd_addr) begin
      rk_rd_r <= nx;
    end else begin
      rk_rd_r <= rk_mem[rd_addr];
    end
  end

  always_comb begin
    st_nxt  = st_r;
    rnd_nxt = rnd_r;
    case (st_r)
      ST_IDLE: begin
        rnd_nxt = '0;
        if (acc) begin
          st_nxt = keys_valid_r ? ST_RUN : ST_KEY;
        end
      end
      ST_KEY: begin
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RndW'(NumRounds - 1)) begin
          st_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == RndW'(NumRounds - 1)) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        rnd_nxt = '0;
        if (out_acc) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // rk_rd_r must hold key 0 (or 31) when a run starts: in IDLE and KEY-last
  // rnd_nxt is 0; key 31, written on the last schedule edge, is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      rnd_r <= '0;
      key_hi_r <= '0; key_lo_r <= '0; iv_hi_r <= '0; iv_lo_r <= '0;
      mode_r <= MODE_CTR;
      keys_valid_r <= 1'b0;
      ctr_r <= '0;
      run_mode_r <= MODE_CTR;
    end else begin
      st_r  <= st_nxt;
      rnd_r <= rnd_nxt;
      if (cfg_acc) begin
        case (cfg_ch.index)
          REG_KEY_HIGH: begin key_hi_r <= cfg_ch.data; keys_valid_r <= 1'b0; end
          REG_KEY_LOW:  begin key_lo_r <= cfg_ch.data; keys_valid_r <= 1'b0; end
          REG_IV_HIGH:  iv_hi_r <= cfg_ch.data;
          REG_IV_LOW:   iv_lo_r <= cfg_ch.data;
          REG_OP_MODE:  mode_r  <= cfg_ch.data[1:0];
          default: ;
        endcase
      end
      if (st_r == ST_KEY && rnd_r == RndW'(NumRounds - 1)) begin
        keys_valid_r <= 1'b1;
      end
      if (acc) begin
        run_mode_r <= mode_r;
        // counter mode steps on from the block used; other modes only reload
        if (mode_r == MODE_CTR) begin
          ctr_r <= src_blk + 128'd1;
        end else if (in_ch.restart) begin
          ctr_r <= {iv_hi_r, iv_lo_r};
        end
      end
    end
  end

  // Payload side: data word, pending block, CK generator, result
  always_ff @(posedge clk) begin
    if (acc) begin
      data_r <= {in_ch.data_high, in_ch.data_low};
      pend_r <= src_blk;
      ck_r   <= CK_STEP;
    end else if (st_r == ST_KEY) begin
      ck_r <= {ck_r[31:24] + 8'd28, ck_r[23:16] + 8'd28, ck_r[15:8] + 8'd28,
               ck_r[7:0] + 8'd28};
    end
    if (st_r == ST_RUN && rnd_r == RndW'(NumRounds - 1)) begin
      res_hi_r <= {nx, w3} ^ ((run_mode_r == MODE_CTR) ? data_r[127:64] : 64'd0);
      res_lo_r <= {w2, w1} ^ ((run_mode_r == MODE_CTR) ? data_r[63:0] : 64'd0);
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_ch.ready) else $error("second word taken while busy");
  a_keys_after_gen: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_KEY && st_nxt == ST_RUN && !cfg_acc) |=> keys_valid_r)
    else $error("keys not marked valid after schedule");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("result dropped");
  a_last_ck: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_KEY && rnd_r == RndW'(NumRounds - 1)) |-> ck_r == CK_LAST)
    else $error("CK sequence off");
`endif
endmodule
